// ===== hw/rtl/tsr_pkg.sv =====
// tsr_pkg: shared types, widths and job codes for the triangle span rasterizer
// used by every module under hw/rtl but tsr_fifo
`default_nettype none

package tsr_pkg;

    localparam int X_W = 10;
    localparam int ROW_W = 6;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TILE_ROWS_DEF = 64;
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // how the back end walks a triangle
    localparam logic [1:0] KIND_BOT = 2'd0;
    localparam logic [1:0] KIND_TOP = 2'd1;
    localparam logic [1:0] KIND_SPLIT = 2'd2;

    typedef struct packed {
        logic [X_W-1:0] vertex_a_x;
        logic [ROW_W-1:0] vertex_a_y;
        logic [X_W-1:0] vertex_b_x;
        logic [ROW_W-1:0] vertex_b_y;
        logic [X_W-1:0] vertex_c_x;
        logic [ROW_W-1:0] vertex_c_y;
    } t_tri;

    typedef struct packed {
        logic [ROW_W-1:0] span_row;
        logic [X_W-1:0] span_start;
        logic [X_W-1:0] span_end;
        logic span_last;
    } t_span;

    // vertices sorted by row, top first
    typedef struct packed {
        logic [X_W-1:0] x0;
        logic [X_W-1:0] x1;
        logic [X_W-1:0] x2;
        logic [ROW_W-1:0] y0;
        logic [ROW_W-1:0] y1;
        logic [ROW_W-1:0] y2;
        logic [1:0] kind;
    } t_job;

endpackage

`default_nettype wire

// ===== hw/rtl/tsr_fifo.sv =====
// tsr_fifo: small register queue with push/full and pop/empty sides
// generic width and depth, no package dependency
`default_nettype none

module tsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic o_full,
    input  wire logic i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic wr_en, rd_en;

    assign o_full = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en = i_push & ~o_full;
    assign rd_en = i_pop & ~o_empty;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("fifo count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> r_count == $past(r_count) + 1'b1)
        else $error("fifo count missed a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && !wr_en) |=> r_count == $past(r_count) - 1'b1)
        else $error("fifo count missed a pop");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_front.sv =====
// tsr_front: clamps vertex rows, sorts the vertices by row and classifies the triangle
// depends on tsr_pkg
`default_nettype none

module tsr_front #(
    parameter int TILE_ROWS = 64
) (
    input  wire tsr_pkg::t_tri i_tri,
    output tsr_pkg::t_job o_job
);
    import tsr_pkg::*;

    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(TILE_ROWS - 1);

    logic [X_W-1:0] ax, bx, cx;
    logic [ROW_W-1:0] ay, by, cy;
    logic [X_W-1:0] x0a, x1a, x0b, x2b, x1c, x2c;
    logic [ROW_W-1:0] y0a, y1a, y0b, y2b, y1c, y2c;

    always_comb begin
        ax = i_tri.vertex_a_x;
        bx = i_tri.vertex_b_x;
        cx = i_tri.vertex_c_x;
        ay = (i_tri.vertex_a_y > ROW_MAX) ? ROW_MAX : i_tri.vertex_a_y;
        by = (i_tri.vertex_b_y > ROW_MAX) ? ROW_MAX : i_tri.vertex_b_y;
        cy = (i_tri.vertex_c_y > ROW_MAX) ? ROW_MAX : i_tri.vertex_c_y;

        // strict compare-swaps: a pair with equal rows is not swapped
        if (by < ay) begin
            x0a = bx; y0a = by; x1a = ax; y1a = ay;
        end else begin
            x0a = ax; y0a = ay; x1a = bx; y1a = by;
        end
        if (cy < y0a) begin
            x0b = cx; y0b = cy; x2b = x0a; y2b = y0a;
        end else begin
            x0b = x0a; y0b = y0a; x2b = cx; y2b = cy;
        end
        if (y2b < y1a) begin
            x1c = x2b; y1c = y2b; x2c = x1a; y2c = y1a;
        end else begin
            x1c = x1a; y1c = y1a; x2c = x2b; y2c = y2b;
        end

        o_job.x0 = x0b;
        o_job.y0 = y0b;
        o_job.x1 = x1c;
        o_job.y1 = y1c;
        o_job.x2 = x2c;
        o_job.y2 = y2c;
        priority if (y1c == y2c) begin
            o_job.kind = KIND_BOT;
        end else if (y0b == y1c) begin
            o_job.kind = KIND_TOP;
        end else begin
            o_job.kind = KIND_SPLIT;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_div.sv =====
// tsr_div: radix-2 restoring divider, (dx << FRAC_BITS) / den truncated toward zero
// depends on tsr_pkg
`default_nettype none

module tsr_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic signed [tsr_pkg::X_W:0] i_dx,
    input  wire logic [tsr_pkg::ROW_W-1:0] i_den,
    output logic o_done,
    output logic signed [tsr_pkg::X_W+FRAC_BITS:0] o_quo
);
    import tsr_pkg::*;

    localparam int NW = X_W + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    logic r_busy, r_neg;
    logic [CNW-1:0] r_cnt;
    logic [NW-1:0] r_dvd, r_q;
    logic [ROW_W-1:0] r_rem, r_den;
    logic [ROW_W:0] trial;
    logic ge;
    logic [X_W-1:0] mag;
    logic [X_W:0] abs_dx;

    assign abs_dx = i_dx[X_W] ? (X_W+1)'(0) - i_dx : i_dx;
    assign mag = abs_dx[X_W-1:0];
    assign trial = {r_rem, r_dvd[NW-1]};
    assign ge = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {mag, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_neg <= i_dx[X_W];
            r_rem <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NW-2:0], 1'b0};
            r_rem <= ge ? ROW_W'(trial - {1'b0, r_den}) : ROW_W'(trial);
            r_q <= {r_q[NW-2:0], ge};
        end
        if (r_busy && r_cnt == CNW'(1)) begin
            o_quo <= r_neg ? -$signed({1'b0, r_q[NW-2:0], ge})
                           : $signed({1'b0, r_q[NW-2:0], ge});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && r_cnt == CNW'(1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("divider done while still busy");
    a_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_start)) |-> r_rem < r_den)
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_back.sv =====
// tsr_back: sequencer that finds split point and slopes, then steps edges row by row
// depends on tsr_pkg and tsr_div
`default_nettype none

module tsr_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire tsr_pkg::t_job i_job,
    output logic o_job_pop,
    output logic o_span_push,
    output tsr_pkg::t_span o_span,
    input  wire logic i_span_full
);
    import tsr_pkg::*;

    localparam int SW = X_W + FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 13;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RATIO = 3'd1;
    localparam logic [2:0] S_XM = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_SLOPE1 = 3'd4;
    localparam logic [2:0] S_SLOPE2 = 3'd5;
    localparam logic [2:0] S_SPAN = 3'd6;

    logic [2:0] r_state;
    t_job r_job;
    logic r_second, r_final, r_desc;
    logic [X_W-1:0] r_xa, r_xp, r_xq;
    logic [ROW_W-1:0] r_dy, r_row;
    logic [ROW_W:0] r_left;
    logic signed [SW-1:0] r_s1, r_s2, r_c1, r_c2;
    logic signed [PW-1:0] r_prod;

    logic div_start, div_done;
    logic signed [X_W:0] div_dx;
    logic [ROW_W-1:0] div_den;
    logic signed [SW-1:0] div_quo;
    logic signed [SW-1:0] lo, hi;
    logic signed [PW-1:0] ratio_ext, dx20_ext, xm_sum;

    tsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_dx(div_dx),
        .i_den(div_den),
        .o_done(div_done),
        .o_quo(div_quo)
    );

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_span_push = (r_state == S_SPAN) && !i_span_full;

    assign ratio_ext = $signed({{(PW-FRAC_BITS-1){1'b0}}, div_quo[FRAC_BITS:0]});
    assign dx20_ext = PW'($signed({1'b0, r_job.x2}) - $signed({1'b0, r_job.x0}));
    assign xm_sum = $signed({{(PW-X_W){1'b0}}, r_job.x0}) + (r_prod >>> FRAC_BITS);

    always_comb begin
        lo = (r_c1 < r_c2) ? r_c1 : r_c2;
        hi = (r_c1 < r_c2) ? r_c2 : r_c1;
        o_span.span_row = r_row;
        o_span.span_start = lo[FRAC_BITS+X_W-1:FRAC_BITS];
        o_span.span_end = hi[FRAC_BITS+X_W-1:FRAC_BITS];
        o_span.span_last = (r_left == (ROW_W+1)'(1)) && r_final;
    end

    always_comb begin
        div_start = 1'b0;
        div_dx = '0;
        div_den = r_dy;
        unique case (r_state)
            S_IDLE: begin
                // split ratio: dy10 / dy20
                div_start = i_job_valid && i_job.kind == KIND_SPLIT;
                div_dx = $signed({{(X_W-ROW_W+1){1'b0}}, i_job.y1 - i_job.y0});
                div_den = i_job.y2 - i_job.y0;
            end
            S_SETUP: begin
                div_start = (r_dy != '0);
                div_dx = $signed({1'b0, r_xp}) - $signed({1'b0, r_xa});
            end
            S_SLOPE1: begin
                div_start = div_done;
                div_dx = $signed({1'b0, r_xq}) - $signed({1'b0, r_xa});
            end
            S_RATIO, S_XM, S_SLOPE2, S_SPAN: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_second <= 1'b0;
            r_final <= 1'b0;
            r_left <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_desc <= (i_job.kind == KIND_TOP);
                        r_second <= 1'b0;
                        r_final <= 1'b1;
                        unique case (i_job.kind)
                            KIND_BOT: begin
                                r_xa <= i_job.x0;
                                r_xp <= i_job.x1;
                                r_xq <= i_job.x2;
                                r_dy <= i_job.y1 - i_job.y0;
                                r_row <= i_job.y0;
                                r_left <= {1'b0, i_job.y1 - i_job.y0} + 1'b1;
                                r_state <= S_SETUP;
                            end
                            KIND_TOP: begin
                                r_xa <= i_job.x2;
                                r_xp <= i_job.x0;
                                r_xq <= i_job.x1;
                                r_dy <= i_job.y2 - i_job.y0;
                                r_row <= i_job.y2;
                                r_left <= {1'b0, i_job.y2 - i_job.y0};
                                r_state <= S_SETUP;
                            end
                            default: begin
                                r_state <= S_RATIO;
                            end
                        endcase
                    end
                end
                S_RATIO: begin
                    if (div_done) begin
                        r_prod <= ratio_ext * dx20_ext;
                        r_state <= S_XM;
                    end
                end
                S_XM: begin
                    // upper part of a split triangle, apex down to the middle row
                    r_xa <= r_job.x0;
                    r_xp <= r_job.x1;
                    r_xq <= xm_sum[X_W-1:0];
                    r_dy <= r_job.y1 - r_job.y0;
                    r_row <= r_job.y0;
                    r_left <= {1'b0, r_job.y1 - r_job.y0} + 1'b1;
                    r_second <= 1'b1;
                    r_final <= 1'b0;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_c1 <= $signed({1'b0, r_xa, {FRAC_BITS{1'b0}}});
                    r_c2 <= $signed({1'b0, r_xa, {FRAC_BITS{1'b0}}});
                    if (r_dy == '0) begin
                        r_s1 <= '0;
                        r_s2 <= '0;
                        r_state <= S_SPAN;
                    end else begin
                        r_state <= S_SLOPE1;
                    end
                end
                S_SLOPE1: begin
                    if (div_done) begin
                        r_s1 <= div_quo;
                        r_state <= S_SLOPE2;
                    end
                end
                S_SLOPE2: begin
                    if (div_done) begin
                        r_s2 <= div_quo;
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (!i_span_full) begin
                        r_c1 <= r_c1 + r_s1;
                        r_c2 <= r_c2 + r_s2;
                        if (r_left == (ROW_W+1)'(1)) begin
                            if (r_second) begin
                                // lower part, bottom vertex up to below the middle row
                                r_xa <= r_job.x2;
                                r_xp <= r_job.x1;
                                r_dy <= r_job.y2 - r_job.y1;
                                r_row <= r_job.y2;
                                r_desc <= 1'b1;
                                r_left <= {1'b0, r_job.y2 - r_job.y1};
                                r_second <= 1'b0;
                                r_final <= 1'b1;
                                r_state <= S_SETUP;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_row <= r_desc ? r_row - 1'b1 : r_row + 1'b1;
                            r_left <= r_left - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_span_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPAN |-> r_left != '0) else $error("span state with no rows left");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_push && o_span.span_last) |=> r_state == S_IDLE)
        else $error("sequencer busy after last span");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == S_IDLE || r_state == S_SETUP || r_state == S_SLOPE1))
        else $error("divider started from wrong state");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_span_rasterizer.sv =====
// triangle_span_rasterizer: top level, front classifier, job queue, back sequencer, span queue
// depends on tsr_pkg, tsr_front, tsr_fifo, tsr_back, tsr_div
//
// Input side is a queue: a triangle item is taken on a clock edge with push high and
// full low. Result side is a queue too: while empty is low the oldest span is on
// o_span, and it is taken on an edge with pop high. span_last marks the final span
// of each triangle; every triangle gives between 1 and TILE_ROWS spans.
// The front clamps, sorts and classifies a triangle in the accepting cycle and
// parks it in a two-entry job queue, so up to two triangles wait behind the one
// being drawn. The back shares one restoring divider, one quotient bit a cycle.
// A flat triangle needs 2 divisions, a split one needs 5, a one-row triangle none.
// After its slope divisions each part's spans leave one per cycle into a two-entry
// output queue while it is not full. When the receiver stalls, the span queue fills
// and the back waits with no loss. Synchronous reset empties both queues and
// returns the sequencer to idle.
`default_nettype none

module triangle_span_rasterizer #(
    parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF,
    parameter int TILE_ROWS = tsr_pkg::TILE_ROWS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic full,
    input  wire tsr_pkg::t_tri i_tri,
    output logic empty,
    input  wire logic pop,
    output tsr_pkg::t_span o_span
);
    import tsr_pkg::*;

    t_job front_job, queued_job;
    t_span back_span;
    logic job_empty, job_pop, span_push, span_full;

    tsr_front #(.TILE_ROWS(TILE_ROWS)) u_front (
        .i_tri(i_tri),
        .o_job(front_job)
    );

    tsr_fifo #(.WIDTH($bits(t_job)), .DEPTH(JOB_DEPTH)) u_job_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(front_job),
        .o_full(full),
        .i_pop(job_pop),
        .o_data(queued_job),
        .o_empty(job_empty)
    );

    tsr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(!job_empty),
        .i_job(queued_job),
        .o_job_pop(job_pop),
        .o_span_push(span_push),
        .o_span(back_span),
        .i_span_full(span_full)
    );

    tsr_fifo #(.WIDTH($bits(t_span)), .DEPTH(OUT_DEPTH)) u_span_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(span_push),
        .i_data(back_span),
        .o_full(span_full),
        .i_pop(pop),
        .o_data(o_span),
        .o_empty(empty)
    );

endmodule

`default_nettype wire

// ===== bench/triangle_span_rasterizer_tb.sv =====
// triangle_span_rasterizer_tb: self-checking bench for the triangle span rasterizer
// predicts the spans of each triangle in functions here and checks each popped span in order
// depends on tsr_pkg and triangle_span_rasterizer
`timescale 1ns / 100ps
`default_nettype none

module triangle_span_rasterizer_tb;
    import tsr_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int ROWS = TILE_ROWS_DEF;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_tri i_tri = '0;
    logic full;
    logic empty;
    t_span o_span;

    t_span span_queue[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit finished = 1'b0;
    bit send_idles = 1'b0;
    bit recv_idles = 1'b0;
    bit recv_hold = 1'b0;

    triangle_span_rasterizer uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_tri(i_tri),
        .empty(empty),
        .pop(pop),
        .o_span(o_span)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint floor_frac(longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint edge_slope(longint dx, longint dy);
        if (dy == 0) return 0;
        return (dx * (longint'(1) << FRAC)) / dy;
    endfunction

    function automatic void add_span(longint row, longint e1, longint e2);
        t_span s;
        longint lo, hi;
        lo = e1 < e2 ? e1 : e2;
        hi = e1 < e2 ? e2 : e1;
        s.span_row = row[ROW_W-1:0];
        s.span_start = X_W'(floor_frac(lo));
        s.span_end = X_W'(floor_frac(hi));
        s.span_last = 1'b0;
        span_queue.insert(span_queue.size(), s);
    endfunction

    // apex down to the flat bottom row, both ends included
    function automatic void fill_bottom(longint x1, longint y1, longint x2, longint y2,
                                        longint x3);
        longint s1, s2, c1, c2;
        s1 = edge_slope(x2 - x1, y2 - y1);
        s2 = edge_slope(x3 - x1, y2 - y1);
        c1 = x1 << FRAC;
        c2 = c1;
        for (longint y = y1; y <= y2; y++) begin
            add_span(y, c1, c2);
            c1 += s1;
            c2 += s2;
        end
    endfunction

    // bottom vertex up to just below the flat top row
    function automatic void fill_top(longint x1, longint y1, longint x2, longint x3,
                                     longint y3);
        longint s1, s2, c1, c2;
        s1 = edge_slope(x1 - x3, y3 - y1);
        s2 = edge_slope(x2 - x3, y3 - y1);
        c1 = x3 << FRAC;
        c2 = c1;
        for (longint y = y3; y > y1; y--) begin
            add_span(y, c1, c2);
            c1 += s1;
            c2 += s2;
        end
    endfunction

    function automatic void predict_spans(t_tri t);
        longint px[3], py[3], tmp, dy10, dy20, ratio, xm;
        int first;
        first = span_queue.size();
        px[0] = longint'(t.vertex_a_x); py[0] = longint'(t.vertex_a_y);
        px[1] = longint'(t.vertex_b_x); py[1] = longint'(t.vertex_b_y);
        px[2] = longint'(t.vertex_c_x); py[2] = longint'(t.vertex_c_y);
        for (int i = 0; i < 3; i++) if (py[i] > ROWS - 1) py[i] = longint'(ROWS - 1);
        if (py[1] < py[0]) begin
            tmp = px[0]; px[0] = px[1]; px[1] = tmp;
            tmp = py[0]; py[0] = py[1]; py[1] = tmp;
        end
        if (py[2] < py[0]) begin
            tmp = px[0]; px[0] = px[2]; px[2] = tmp;
            tmp = py[0]; py[0] = py[2]; py[2] = tmp;
        end
        if (py[2] < py[1]) begin
            tmp = px[1]; px[1] = px[2]; px[2] = tmp;
            tmp = py[1]; py[1] = py[2]; py[2] = tmp;
        end
        if (py[1] == py[2]) begin
            fill_bottom(px[0], py[0], px[1], py[1], px[2]);
        end else if (py[0] == py[1]) begin
            fill_top(px[0], py[0], px[1], px[2], py[2]);
        end else begin
            dy10 = py[1] - py[0];
            dy20 = py[2] - py[0];
            ratio = (dy10 << FRAC) / dy20;
            xm = px[0] + floor_frac(ratio * (px[2] - px[0]));
            fill_bottom(px[0], py[0], px[1], py[1], xm);
            fill_top(px[1], py[1], xm, px[2], py[2]);
        end
        if (span_queue.size() > first) span_queue[span_queue.size()-1].span_last = 1'b1;
    endfunction

    // push stays high after the accepting edge; an idling next send or the drain drops it
    task automatic send_tri(t_tri t);
        if (send_idles) begin
            while ($urandom_range(99) < 7) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        i_tri <= t;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_spans(t);
    endtask

    function automatic t_tri make_tri(int ax, int ay, int bx, int by, int cx, int cy);
        t_tri t;
        t.vertex_a_x = X_W'(ax); t.vertex_a_y = ROW_W'(ay);
        t.vertex_b_x = X_W'(bx); t.vertex_b_y = ROW_W'(by);
        t.vertex_c_x = X_W'(cx); t.vertex_c_y = ROW_W'(cy);
        return t;
    endfunction

    function automatic t_tri random_tri();
        t_tri t;
        int base, h;
        t = t_tri'($bits(t_tri)'({$urandom, $urandom}));
        // mostly short triangles keep the run quick, a few span the tile
        if ($urandom_range(9) != 0) begin
            base = $urandom_range(63);
            h = $urandom_range(8);
            t.vertex_a_y = ROW_W'(base);
            t.vertex_b_y = ROW_W'((base + $urandom_range(h)) % 64);
            t.vertex_c_y = ROW_W'((base + $urandom_range(h)) % 64);
        end
        if ($urandom_range(7) == 0) t.vertex_b_y = t.vertex_a_y;
        if ($urandom_range(7) == 0) t.vertex_c_y = t.vertex_b_y;
        return t;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (span_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corners();
        send_tri(make_tri(0, 0, 0, 0, 0, 0));
        send_tri(make_tri(1023, 63, 1023, 63, 1023, 63));
        send_tri(make_tri(517, 20, 3, 20, 900, 20));
        send_tri(make_tri(500, 0, 0, 63, 1023, 63));
        send_tri(make_tri(0, 0, 1023, 0, 512, 63));
        send_tri(make_tri(0, 0, 1023, 31, 100, 63));
        send_tri(make_tri(1023, 63, 0, 0, 600, 17));
        send_tri(make_tri(10, 5, 20, 5, 30, 6));
        send_tri(make_tri(10, 5, 20, 6, 30, 6));
        send_tri(make_tri(1023, 1, 0, 0, 1023, 2));
        send_tri(make_tri(300, 40, 300, 10, 300, 25));
        send_tri(make_tri(682, 42, 341, 21, 0, 0));
        send_tri(make_tri(5, 33, 1000, 33, 5, 12));
        send_tri(make_tri(1023, 0, 0, 1, 1023, 63));
        send_tri(make_tri(0, 63, 1023, 62, 0, 0));
        send_tri(make_tri(777, 7, 123, 50, 1022, 50));
        wait_drained();
    endtask

    task automatic test_random(int count);
        send_idles = 1'b0;
        recv_idles = 1'b0;
        for (int i = 0; i < count; i++) begin
            // first stretch runs with no idling on either side
            if (i == 40) begin
                send_idles = 1'b1;
                recv_idles = 1'b1;
            end
            send_tri(random_tri());
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                for (int i = 0; i < 600; i++) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_tri(random_tri());
        join
        wait_drained();
    endtask

    // result side: pop driven at the edge, span taken when pop and not empty
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (span_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected span row %0d start %0d end %0d",
                    o_span.span_row, o_span.span_start, o_span.span_end);
            end else begin
                if (o_span !== span_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("span mismatch exp r%0d s%0d e%0d l%0d got r%0d s%0d e%0d l%0d",
                            span_queue[0].span_row, span_queue[0].span_start,
                            span_queue[0].span_end, span_queue[0].span_last,
                            o_span.span_row, o_span.span_start, o_span.span_end,
                            o_span.span_last);
                end
                void'(span_queue.pop_front());
            end
        end
        pop <= !recv_hold && !(recv_idles && $urandom_range(99) < 7);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || recv_hold || finished)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("triangle_span_rasterizer_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_backpressure();
        test_random(240);
        finished = 1'b1;
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && span_queue.size() == 0)
            $display("triangle_span_rasterizer_tb: clean");
        else
            $display("triangle_span_rasterizer_tb: errors");
        $finish;
    end
endmodule

`default_nettype wire

// ===== triangle_span_rasterizer.f =====
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_fifo.sv
hw/rtl/tsr_front.sv
hw/rtl/tsr_div.sv
hw/rtl/tsr_back.sv
hw/rtl/triangle_span_rasterizer.sv
bench/triangle_span_rasterizer_tb.sv
